// ----- rtl/core/tgc_pkg.sv -----
package tgc_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int FRAC_BITS   = 4;

	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	localparam int POS_W   = 20;
	localparam int BOX_W   = 16;
	localparam int TILE_W  = 8;
	localparam int SIZE_W  = 8;
	localparam int MAP_W   = 7;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;

	// coordinates at doubled scale plus up to twice the box size
	localparam int COORD_W = POS_W + 2;
	// divisor is size << (FRAC_BITS + 1); the shift is folded into the dividend
	localparam int SHIFT   = FRAC_BITS + 1;
	localparam int DIV_W   = COORD_W - 1 - SHIFT;
	localparam int CNT_W   = $clog2(DIV_W + 1);

	localparam int SAMPLE_W = 3;
	localparam logic [SAMPLE_W-1:0] LAST_SAMPLE = SAMPLE_W'(7);

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_POINT = 2'd2,
		OP_BOX   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 2'd0,
		REG_TILE_HEIGHT = 2'd1,
		REG_MAP_COLUMNS = 2'd2,
		REG_MAP_ROWS    = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XSTART,
		ST_XWAIT,
		ST_YSTART,
		ST_YWAIT,
		ST_CHECK,
		ST_ACCESS,
		ST_RDATA,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [BOX_W-1:0]        box_w;
		logic [BOX_W-1:0]        box_h;
		logic [TILE_W-1:0]       new_tile;
	} in_payload_t;

	typedef struct packed {
		logic [TILE_W-1:0] tile_value;
		logic              in_bounds;
		logic              hit;
	} out_payload_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [TILE_W-1:0] wdata;
	} ram_req_t;

	// box samples walk corners and edge midpoints clockwise from top left;
	// each entry is the multiple of the box size added at doubled scale
	function automatic logic [1:0] sample_x_mul(input logic [SAMPLE_W-1:0] s);
		logic [1:0] m;
		unique case (s)
			3'd0: m = 2'd0;
			3'd1: m = 2'd1;
			3'd2: m = 2'd2;
			3'd3: m = 2'd2;
			3'd4: m = 2'd2;
			3'd5: m = 2'd1;
			3'd6: m = 2'd0;
			3'd7: m = 2'd0;
			default: m = 2'd0;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] sample_y_mul(input logic [SAMPLE_W-1:0] s);
		logic [1:0] m;
		unique case (s)
			3'd0: m = 2'd0;
			3'd1: m = 2'd0;
			3'd2: m = 2'd0;
			3'd3: m = 2'd1;
			3'd4: m = 2'd2;
			3'd5: m = 2'd2;
			3'd6: m = 2'd2;
			3'd7: m = 2'd1;
			default: m = 2'd0;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/core/tgc_div.sv -----
module tgc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  tgc_pkg::div_req_t req,
	output tgc_pkg::div_rsp_t rsp
);
	import tgc_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [SIZE_W:0]   trial;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= SIZE_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[SIZE_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/core/tgc_ram.sv -----
module tgc_ram (
	input  logic                        clk,
	input  tgc_pkg::ram_req_t           req,
	output logic [tgc_pkg::TILE_W-1:0]  rdata
);
	import tgc_pkg::*;

	logic [TILE_W-1:0] mem_q [DEPTH];
	logic [TILE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tile_grid_collision_store_top.sv -----
// Tile grid with point and box collision queries.
// Input channel in_valid/in_stall/in_data carries one request: op, position,
// box size and a tile number for writes. A transfer happens when valid is high
// and stall is low. Output channel out_valid/out_stall/out_data returns one
// result per request: tile value, in-bounds flag and hit flag.
// The config port (cfg_we, cfg_index, cfg_data) writes tile width, tile height,
// map columns and map rows; write it only while no request is in flight.
// Each tile coordinate comes from one shared 16-step restoring divider. A
// sample runs two divisions (x, then y), a bounds and index step, a RAM
// access step and a RAM data step. Read, write and point test take one
// sample. A box test takes one sample per corner and edge midpoint, stopping
// at the first hit. in_stall is high while a request is in work. The result
// sits in an output register; the next request is taken while it waits, and
// the sequencer holds in its final state if the receiver still stalls the
// earlier result. Reset clears the sequencer, the output valid and the
// config registers (16, 16, 64, 64); tile RAM contents are undefined until
// written.
module tile_grid_collision_store_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tgc_pkg::in_payload_t               in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tgc_pkg::out_payload_t              out_data,
	input  logic                               cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0]          cfg_data
);
	import tgc_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [SIZE_W-1:0] tile_width_q;
	logic [SIZE_W-1:0] tile_height_q;
	logic [MAP_W-1:0]  map_columns_q;
	logic [MAP_W-1:0]  map_rows_q;

	// request and per-sample working registers
	in_payload_t       req_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic              xneg_q;
	logic              yneg_q;
	logic [DIV_W-1:0]  tx_q;
	logic [DIV_W-1:0]  ty_q;
	logic              inb_q;
	logic [ADDR_W-1:0] idx_q;
	logic              hit_q;

	logic              out_valid_q;
	out_payload_t      out_q;

	// derived values
	logic [SIZE_W-1:0]  tw_eff;
	logic [SIZE_W-1:0]  th_eff;
	logic [MAP_W-1:0]   cols_eff;
	logic [MAP_W-1:0]   rows_eff;
	logic [COORD_W-1:0] x2;
	logic [COORD_W-1:0] y2;
	logic [COORD_W-1:0] x_off;
	logic [COORD_W-1:0] y_off;
	logic [COORD_W-1:0] nx;
	logic [COORD_W-1:0] ny;
	logic               last_sample;
	logic               sample_hit;
	logic               out_free;
	logic               tile_nz;
	logic               sel_y;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	ram_req_t          ram_req;
	logic [TILE_W-1:0] ram_rdata;
	out_payload_t      result;

	tgc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tgc_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// a zero tile size acts as one; map size saturates to the grid
	assign tw_eff   = (tile_width_q == '0) ? SIZE_W'(1) : tile_width_q;
	assign th_eff   = (tile_height_q == '0) ? SIZE_W'(1) : tile_height_q;
	assign cols_eff = (32'(map_columns_q) > MAX_COLUMNS) ? MAP_W'(MAX_COLUMNS) : map_columns_q;
	assign rows_eff = (32'(map_rows_q) > MAX_ROWS) ? MAP_W'(MAX_ROWS) : map_rows_q;

	// sample position at doubled scale: midpoint offsets stay exact
	assign x2 = {req_q.pos_x[POS_W-1], req_q.pos_x, 1'b0};
	assign y2 = {req_q.pos_y[POS_W-1], req_q.pos_y, 1'b0};

	always_comb begin
		unique case (sample_x_mul(sample_q))
			2'd1:    x_off = COORD_W'(req_q.box_w);
			2'd2:    x_off = COORD_W'({req_q.box_w, 1'b0});
			default: x_off = '0;
		endcase
		unique case (sample_y_mul(sample_q))
			2'd1:    y_off = COORD_W'(req_q.box_h);
			2'd2:    y_off = COORD_W'({req_q.box_h, 1'b0});
			default: y_off = '0;
		endcase
	end

	assign nx = x2 + x_off;
	assign ny = y2 + y_off;

	assign tile_nz     = ram_rdata != '0;
	assign sample_hit  = inb_q && tile_nz;
	assign last_sample = (req_q.op != OP_BOX) || (sample_q == LAST_SAMPLE);
	assign out_free    = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_XSTART;
			end
			ST_XSTART: state_d = ST_XWAIT;
			ST_XWAIT: begin
				if (div_rsp.done) state_d = ST_YSTART;
			end
			ST_YSTART: state_d = ST_YWAIT;
			ST_YWAIT: begin
				if (div_rsp.done) state_d = ST_CHECK;
			end
			ST_CHECK:  state_d = ST_ACCESS;
			ST_ACCESS: state_d = ST_RDATA;
			ST_RDATA: begin
				if (last_sample || sample_hit) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_XSTART;
				end
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		sel_y       = 1'b0;
		div_req     = '0;
		ram_req     = '0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_XSTART: div_req.start = 1'b1;
			ST_YSTART: begin
				div_req.start = 1'b1;
				sel_y         = 1'b1;
			end
			ST_ACCESS: begin
				ram_req.re = 1'b1;
				ram_req.we = inb_q && (req_q.op == OP_WRITE);
			end
			default: ;
		endcase
		// negative positions are out of bounds; the quotient is then ignored
		div_req.dividend = sel_y ? ny[COORD_W-2:SHIFT] : nx[COORD_W-2:SHIFT];
		div_req.divisor  = sel_y ? th_eff : tw_eff;
		ram_req.addr     = idx_q;
		ram_req.wdata    = req_q.new_tile;
	end

	// result formatting per operation
	always_comb begin
		result = '0;
		unique case (req_q.op)
			OP_READ, OP_POINT: begin
				result.tile_value = inb_q ? ram_rdata : '0;
				result.in_bounds  = inb_q;
				result.hit        = sample_hit;
			end
			OP_WRITE: result.in_bounds = inb_q;
			OP_BOX:   result.hit       = hit_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= SIZE_W'(16);
			tile_height_q <= SIZE_W'(16);
			map_columns_q <= MAP_W'(64);
			map_rows_q    <= MAP_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data[SIZE_W-1:0];
				REG_TILE_HEIGHT: tile_height_q <= cfg_data[SIZE_W-1:0];
				REG_MAP_COLUMNS: map_columns_q <= cfg_data[MAP_W-1:0];
				REG_MAP_ROWS:    map_rows_q    <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q    <= in_data;
					sample_q <= '0;
					hit_q    <= 1'b0;
				end
			end
			ST_XSTART: xneg_q <= nx[COORD_W-1];
			ST_XWAIT: begin
				if (div_rsp.done) tx_q <= div_rsp.quotient;
			end
			ST_YSTART: yneg_q <= ny[COORD_W-1];
			ST_YWAIT: begin
				if (div_rsp.done) ty_q <= div_rsp.quotient;
			end
			ST_CHECK: begin
				inb_q <= !xneg_q && !yneg_q
					&& (tx_q < DIV_W'(cols_eff)) && (ty_q < DIV_W'(rows_eff));
				idx_q <= ADDR_W'(tx_q[COL_W-1:0])
					+ ADDR_W'(ty_q[ROW_W-1:0]) * ADDR_W'(cols_eff);
			end
			ST_RDATA: begin
				hit_q    <= hit_q | sample_hit;
				sample_q <= sample_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register: load on finish, drop valid on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
